FILE: rtl/ahs_pkg.sv
// Package with the types, codes and constants of the axis homing sequencer.
`default_nettype none

package ahs_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DIST_W     = 24;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QAW        = $clog2(QDEPTH);

  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [DATA_W:0]  DEADBAND = (DATA_W+1)'(3);

  localparam int unsigned ST_ALARM_BIT  = 0;
  localparam int unsigned ST_BUSY_BIT   = 2;
  localparam int unsigned ST_POSLIM_BIT = 4;
  localparam int unsigned ST_NEGLIM_BIT = 5;

  localparam logic [7:0] SR_POSLIM = 8'h04;
  localparam logic [7:0] SR_NEGLIM = 8'h05;
  localparam logic [7:0] SR_INPUT  = 8'h0b;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_CANCEL = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SEEK  = 3'd1,
    PH_BACK  = 3'd2,
    PH_HOMED = 3'd3,
    PH_FAULT = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_JOG     = 3'd1,
    CMD_BACKOFF = 3'd2,
    CMD_ZERO    = 3'd3,
    CMD_STOP    = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    FLT_NONE     = 3'd0,
    FLT_ALARM    = 3'd1,
    FLT_SEEK_TO  = 3'd2,
    FLT_BACK_TO  = 3'd3,
    FLT_CANCEL   = 3'd4
  } fault_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOME_NEG_X   = 3'd0,
    REG_HOME_NEG_Y   = 3'd1,
    REG_BACKOFF_X    = 3'd2,
    REG_BACKOFF_Y    = 3'd3,
    REG_MIN_MOVE     = 3'd4,
    REG_STABLE_MS    = 3'd5,
    REG_SEEK_TO_MS   = 3'd6,
    REG_BACK_TO_MS   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic              home_neg_x;
    logic              home_neg_y;
    logic [DIST_W-1:0] backoff_x;
    logic [DIST_W-1:0] backoff_y;
    logic [DIST_W-1:0] min_move;
    logic [MS_W-1:0]   stable_ms;
    logic [MS_W-1:0]   seek_to_ms;
    logic [MS_W-1:0]   back_to_ms;
  } cfg_t;

  typedef struct packed {
    req_t              kind;
    logic              axis_sel;
    logic              alarm;
    logic              busy;
    logic              lim_pos;
    logic              lim_neg;
    logic              sr_input;
    logic [DATA_W-1:0] encoder;
    logic [DATA_W-1:0] planned;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/axis_homing_sequencer_top.sv
// Top level of the axis homing sequencer: register file, front end, queue, back end.
// Throughput: one word per cycle while the queue has room and the result is not stalled;
// every input word yields exactly one result word. An accepted word is written into the
// queue, then popped into the result register, where it stays valid until it is taken.
// A four-entry queue lets the front end take words while the result register stalls.
// Reset (synchronous, active low) returns to idle, clears the queue and restores
// the register defaults; there is no clearing pass.
`default_nettype none

module axis_homing_sequencer_top
  import ahs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_req_type,
  input  wire logic                   in_axis_select,
  input  wire logic [DATA_W-1:0]      in_status_bits,
  input  wire logic [7:0]             in_stop_reason,
  input  wire logic signed [DATA_W-1:0] in_encoder_pos,
  input  wire logic signed [DATA_W-1:0] in_planned_pos,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2:0]                  out_command,
  output logic signed [DATA_W-1:0]    out_target_pos,
  output logic [2:0]                  out_phase,
  output logic [2:0]                  out_fault_code,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t  cfg_r;
  item_t push_item, head_item;
  logic  q_full, q_push, q_pop, head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.home_neg_x <= 1'b1;
      cfg_r.home_neg_y <= 1'b1;
      cfg_r.backoff_x  <= DIST_W'(1000);
      cfg_r.backoff_y  <= DIST_W'(1000);
      cfg_r.min_move   <= DIST_W'(100);
      cfg_r.stable_ms  <= MS_W'(200);
      cfg_r.seek_to_ms <= MS_W'(30000);
      cfg_r.back_to_ms <= MS_W'(10000);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HOME_NEG_X: cfg_r.home_neg_x <= cfg_wdata[0];
        REG_HOME_NEG_Y: cfg_r.home_neg_y <= cfg_wdata[0];
        REG_BACKOFF_X:  cfg_r.backoff_x  <= cfg_wdata[DIST_W-1:0];
        REG_BACKOFF_Y:  cfg_r.backoff_y  <= cfg_wdata[DIST_W-1:0];
        REG_MIN_MOVE:   cfg_r.min_move   <= cfg_wdata[DIST_W-1:0];
        REG_STABLE_MS:  cfg_r.stable_ms  <= cfg_wdata[MS_W-1:0];
        REG_SEEK_TO_MS: cfg_r.seek_to_ms <= cfg_wdata[MS_W-1:0];
        REG_BACK_TO_MS: cfg_r.back_to_ms <= cfg_wdata[MS_W-1:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  ahs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_axis_select (in_axis_select),
    .in_status_bits (in_status_bits),
    .in_stop_reason (in_stop_reason),
    .in_encoder_pos (in_encoder_pos),
    .in_planned_pos (in_planned_pos),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  ahs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ahs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_command    (out_command),
    .out_target_pos (out_target_pos),
    .out_phase      (out_phase),
    .out_fault_code (out_fault_code)
  );

endmodule

`default_nettype wire

FILE: rtl/ahs_front.sv
// Front end: accepts input words and classifies them into queue items.
`default_nettype none

module ahs_front
  import ahs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_req_type,
  input  wire logic                in_axis_select,
  input  wire logic [DATA_W-1:0]   in_status_bits,
  input  wire logic [7:0]          in_stop_reason,
  input  wire logic signed [DATA_W-1:0] in_encoder_pos,
  input  wire logic signed [DATA_W-1:0] in_planned_pos,
  input  wire logic                q_full,
  output logic                     q_push,
  output item_t                    q_item
);

  logic seen_r;

  assign in_ready = rst_n && !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.kind     = req_t'(in_req_type);
    q_item.axis_sel = in_axis_select;
    q_item.alarm    = in_status_bits[ST_ALARM_BIT];
    q_item.busy     = in_status_bits[ST_BUSY_BIT];
    q_item.lim_pos  = in_status_bits[ST_POSLIM_BIT] || (in_stop_reason == SR_POSLIM);
    q_item.lim_neg  = in_status_bits[ST_NEGLIM_BIT] || (in_stop_reason == SR_NEGLIM);
    q_item.sr_input = (in_stop_reason == SR_INPUT);
    q_item.encoder  = in_encoder_pos;
    q_item.planned  = in_planned_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (q_push) begin
      seen_r <= 1'b1;
    end
  end

  property p_no_push_before_reset_release;
    @(posedge clk) !rst_n |-> !q_push;
  endproperty
  a_no_push_in_reset: assert property (p_no_push_before_reset_release)
    else $error("front pushed a word during reset");

  property p_push_needs_room;
    @(posedge clk) disable iff (!rst_n) q_push |-> !q_full && (seen_r || !seen_r);
  endproperty
  a_push_room: assert property (p_push_needs_room)
    else $error("front pushed into a full queue");

endmodule

`default_nettype wire

FILE: rtl/ahs_fifo.sv
// Short item queue between the front end and the sequencer back end.
`default_nettype none

module ahs_fifo
  import ahs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  item_t     push_item,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output item_t     head_item
);

  item_t           mem_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]    count_r, count_nxt;

  assign full       = (count_r == (QAW+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  property p_pop_needs_data;
    @(posedge clk) disable iff (!rst_n) pop |-> head_valid;
  endproperty
  a_pop_data: assert property (p_pop_needs_data)
    else $error("queue popped while empty");

  property p_count_tracks_ptrs;
    @(posedge clk) disable iff (!rst_n)
      count_r <= (QAW+1)'(QDEPTH) && (wr_ptr_r - rd_ptr_r) == count_r[QAW-1:0];
  endproperty
  a_count: assert property (p_count_tracks_ptrs)
    else $error("queue count and pointers disagree");

endmodule

`default_nettype wire

FILE: rtl/ahs_back.sv
// Back end: homing state machine, counters and the result register.
`default_nettype none

module ahs_back
  import ahs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  cfg_t                   cfg,
  input  wire logic              head_valid,
  input  item_t                  head_item,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_command,
  output logic signed [DATA_W-1:0] out_target_pos,
  output logic [2:0]             out_phase,
  output logic [2:0]             out_fault_code
);

  phase_t             phase_r, phase_nxt;
  fault_t             fault_r, fault_nxt;
  logic               axis_r, axis_nxt;
  logic [DATA_W-1:0]  start_enc_r, start_enc_nxt;
  logic [DATA_W-1:0]  last_enc_r, last_enc_nxt;
  logic [CNT_W-1:0]   stable_r, stable_nxt;
  logic [CNT_W-1:0]   elapsed_r, elapsed_nxt;
  cmd_t               cmd_nxt;
  logic [DATA_W-1:0]  tgt_nxt;

  logic               out_valid_r;
  cmd_t               out_cmd_r;
  logic [DATA_W-1:0]  out_tgt_r;
  phase_t             out_phase_r;
  fault_t             out_fault_r;

  logic               active, is_start;
  logic               sel_axis, sel_neg, lim_now;
  logic [DIST_W-1:0]  sel_dist;
  logic [DATA_W-1:0]  target;
  logic signed [DATA_W:0] d_last, d_start;
  logic [DATA_W:0]    abs_last, abs_start;
  logic               rearm, moved, still, seek_done;
  logic [CNT_W-1:0]   stable_eff, stable_inc, elapsed_inc;
  logic               seek_to, back_to;

  assign pop = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    active   = (phase_r == PH_SEEK) || (phase_r == PH_BACK);
    is_start = (head_item.kind == REQ_START);
    sel_axis = is_start ? head_item.axis_sel : axis_r;
    sel_neg  = sel_axis ? cfg.home_neg_x : cfg.home_neg_y;
    sel_dist = sel_axis ? cfg.backoff_x : cfg.backoff_y;
    lim_now  = sel_neg ? head_item.lim_neg : head_item.lim_pos;
    target   = sel_neg ? head_item.planned + {{(DATA_W-DIST_W){1'b0}}, sel_dist}
                       : head_item.planned - {{(DATA_W-DIST_W){1'b0}}, sel_dist};

    d_last    = $signed({head_item.encoder[DATA_W-1], head_item.encoder})
              - $signed({last_enc_r[DATA_W-1], last_enc_r});
    d_start   = $signed({head_item.encoder[DATA_W-1], head_item.encoder})
              - $signed({start_enc_r[DATA_W-1], start_enc_r});
    abs_last  = d_last[DATA_W] ? (DATA_W+1)'(-d_last) : (DATA_W+1)'(d_last);
    abs_start = d_start[DATA_W] ? (DATA_W+1)'(-d_start) : (DATA_W+1)'(d_start);
    rearm     = abs_last > DEADBAND;
    moved     = abs_start >= {{(DATA_W+1-DIST_W){1'b0}}, cfg.min_move};
    stable_eff = rearm ? '0 : stable_r;
    still     = !head_item.busy && (stable_eff >= {{(CNT_W-MS_W){1'b0}}, cfg.stable_ms});
    seek_done = lim_now || head_item.sr_input || (moved && still);

    stable_inc  = (stable_r == CNT_MAX) ? stable_r : stable_r + 1'b1;
    elapsed_inc = (elapsed_r == CNT_MAX) ? elapsed_r : elapsed_r + 1'b1;
    seek_to = elapsed_inc > {{(CNT_W-MS_W){1'b0}}, cfg.seek_to_ms};
    back_to = elapsed_inc > {{(CNT_W-MS_W){1'b0}}, cfg.back_to_ms};
  end

  always_comb begin
    phase_nxt = phase_r;
    unique case (head_item.kind)
      REQ_START: begin
        if (!active) begin
          phase_nxt = lim_now ? PH_BACK : PH_SEEK;
        end
      end
      REQ_CANCEL: begin
        if (active) begin
          phase_nxt = PH_FAULT;
        end
      end
      REQ_TICK: begin
        if ((phase_r == PH_SEEK && seek_to) || (phase_r == PH_BACK && back_to)) begin
          phase_nxt = PH_FAULT;
        end
      end
      REQ_SAMPLE: begin
        if (phase_r == PH_SEEK) begin
          if (seek_done) begin
            phase_nxt = PH_BACK;
          end else if (head_item.alarm) begin
            phase_nxt = PH_FAULT;
          end
        end else if (phase_r == PH_BACK && !head_item.busy) begin
          phase_nxt = PH_HOMED;
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  always_comb begin
    cmd_nxt       = CMD_NONE;
    tgt_nxt       = '0;
    fault_nxt     = fault_r;
    axis_nxt      = axis_r;
    start_enc_nxt = start_enc_r;
    last_enc_nxt  = last_enc_r;
    stable_nxt    = stable_r;
    elapsed_nxt   = elapsed_r;
    unique case (head_item.kind)
      REQ_START: begin
        if (!active) begin
          axis_nxt      = head_item.axis_sel;
          fault_nxt     = FLT_NONE;
          start_enc_nxt = head_item.encoder;
          last_enc_nxt  = head_item.encoder;
          stable_nxt    = '0;
          elapsed_nxt   = '0;
          if (lim_now) begin
            cmd_nxt = CMD_BACKOFF;
            tgt_nxt = target;
          end else begin
            cmd_nxt = CMD_JOG;
          end
        end
      end
      REQ_CANCEL: begin
        if (active) begin
          fault_nxt = FLT_CANCEL;
          cmd_nxt   = CMD_STOP;
        end
      end
      REQ_TICK: begin
        if (active) begin
          elapsed_nxt = elapsed_inc;
          stable_nxt  = stable_inc;
          if (phase_r == PH_SEEK && seek_to) begin
            fault_nxt = FLT_SEEK_TO;
            cmd_nxt   = CMD_STOP;
          end else if (phase_r == PH_BACK && back_to) begin
            fault_nxt = FLT_BACK_TO;
            cmd_nxt   = CMD_STOP;
          end
        end
      end
      REQ_SAMPLE: begin
        if (phase_r == PH_SEEK) begin
          if (rearm) begin
            last_enc_nxt = head_item.encoder;
            stable_nxt   = '0;
          end
          if (seek_done) begin
            cmd_nxt     = CMD_BACKOFF;
            tgt_nxt     = target;
            elapsed_nxt = '0;
          end else if (head_item.alarm) begin
            fault_nxt = FLT_ALARM;
            cmd_nxt   = CMD_STOP;
          end
        end else if (phase_r == PH_BACK && !head_item.busy) begin
          cmd_nxt = CMD_ZERO;
        end
      end
      default: cmd_nxt = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      fault_r     <= FLT_NONE;
      axis_r      <= 1'b0;
      start_enc_r <= '0;
      last_enc_r  <= '0;
      stable_r    <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r     <= phase_nxt;
        fault_r     <= fault_nxt;
        axis_r      <= axis_nxt;
        start_enc_r <= start_enc_nxt;
        last_enc_r  <= last_enc_nxt;
        stable_r    <= stable_nxt;
        elapsed_r   <= elapsed_nxt;
      end
      out_valid_r <= pop || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_cmd_r   <= cmd_nxt;
      out_tgt_r   <= tgt_nxt;
      out_phase_r <= phase_nxt;
      out_fault_r <= fault_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_command    = out_cmd_r;
  assign out_target_pos = out_tgt_r;
  assign out_phase      = out_phase_r;
  assign out_fault_code = out_fault_r;

  property p_fault_phase_has_code;
    @(posedge clk) disable iff (!rst_n) (phase_r == PH_FAULT) |-> (fault_r != FLT_NONE);
  endproperty
  a_fault_code: assert property (p_fault_phase_has_code)
    else $error("fault phase without a fault code");

  property p_stop_enters_fault;
    @(posedge clk) disable iff (!rst_n)
      (pop && cmd_nxt == CMD_STOP) |=> (phase_r == PH_FAULT) && (out_phase_r == PH_FAULT);
  endproperty
  a_stop_fault: assert property (p_stop_enters_fault)
    else $error("stop command without entry into fault");

  property p_backoff_enters_back;
    @(posedge clk) disable iff (!rst_n)
      (pop && cmd_nxt == CMD_BACKOFF) |=> (phase_r == PH_BACK) && (elapsed_r == '0);
  endproperty
  a_backoff: assert property (p_backoff_enters_back)
    else $error("backoff command without a fresh backoff phase");

endmodule

`default_nettype wire
